[hdl/bounded_id_set_unit_assert.svh]
// Assertion macros used by the checker file of the bounded id set unit
`ifndef BOUNDED_ID_SET_UNIT_ASSERT_SVH
`define BOUNDED_ID_SET_UNIT_ASSERT_SVH

// Clocked assertion, switched off while reset is high
`define BIS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define BIS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/bis_pkg.sv]
// Package of the bounded id set unit: sizes, action codes, states and port structs
package bis_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int ID_W     = 32;
   localparam int ACT_W    = 2;
   localparam int POS_W    = 4;
   localparam int CNT_OUT_W = 5;

   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam logic [ID_W-1:0]  NULL_ID = '1;

   localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
   localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_RESOLVE,
      S_LAST_RD,
      S_LAST_WR,
      S_DONE
   } state_type;

   // Status of the compare unit for the entry read in the previous cycle
   typedef struct packed {
      logic             hit;
      logic             miss;
      logic [IDX_W-1:0] idx;
   } scan_stat_type;

   // One read and one write request towards the entry memory
   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             we;
      logic [IDX_W-1:0] wr_addr;
      logic [ID_W-1:0]  wr_data;
   } mem_req_type;

endpackage

[hdl/bis_store.sv]
// Entry memory of the bounded id set unit: one write port, one registered read port
module bis_store (
   input  logic                        clock,
   input  bis_pkg::mem_req_type        mem_req,
   output logic [bis_pkg::ID_W-1:0]    rd_data
);

   logic [bis_pkg::ID_W-1:0] mem_ff [bis_pkg::CAPACITY];
   logic [bis_pkg::ID_W-1:0] rd_data_ff;

   // Write the entry and register the read data
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/bis_scan.sv]
// Linear search unit: walks the stored entries and compares each with the id
module bis_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          run,
   input  logic [bis_pkg::CNT_W-1:0]     count,
   input  logic [bis_pkg::ID_W-1:0]      id,
   input  logic [bis_pkg::ID_W-1:0]      rd_data,
   output logic                          rd_en,
   output logic [bis_pkg::IDX_W-1:0]     rd_addr,
   output bis_pkg::scan_stat_type        stat
);

   logic [bis_pkg::CNT_W-1:0] scan_ff, scan_in;
   logic                      pend_ff, pend_in;
   logic [bis_pkg::IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic                      issue;
   logic                      match;

   // Issue one read per cycle while entries remain below the count
   always_comb begin
      issue       = run && !start && (scan_ff < count);
      scan_in     = scan_ff;
      if (start) begin
         scan_in = '0;
      end else if (issue) begin
         scan_in = scan_ff + bis_pkg::CNT_W'(1);
      end
      pend_in     = issue;
      pend_idx_in = scan_ff[bis_pkg::IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
      end
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
   end

   // Compare the returned entry; flag a miss on the last stored slot
   always_comb begin
      match     = (rd_data == id);
      stat.hit  = pend_ff && match;
      stat.miss = pend_ff && !match &&
                  (bis_pkg::CNT_W'(pend_idx_ff) == (count - bis_pkg::CNT_W'(1)));
      stat.idx  = pend_idx_ff;
   end

   assign rd_en   = issue;
   assign rd_addr = scan_ff[bis_pkg::IDX_W-1:0];

endmodule

[hdl/bounded_id_set_unit.sv]
// Flow: for the null id or an empty set an accepted request passes the resolve
//   and done states; otherwise a search over the stored ids comes first, and a
//   delete that hits also passes the last-read and last-write states. Only one
//   transaction at a time, scanned via the single read port of the entry memory.
// Reset: synchronous; clears the count, the sequencer and the result valid.
//   Entries are not cleared; only slots below the count are ever read.
module bounded_id_set_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [bis_pkg::ACT_W-1:0]         req_action,
   input  logic signed [bis_pkg::ID_W-1:0]   req_id,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_ok,
   output logic                              rsp_found,
   output logic [bis_pkg::POS_W-1:0]         rsp_position,
   output logic [bis_pkg::CNT_OUT_W-1:0]     rsp_count
);

   bis_pkg::state_type          state_ff, state_in;
   logic [bis_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [bis_pkg::ACT_W-1:0]   action_ff, action_in;
   logic [bis_pkg::ID_W-1:0]    id_ff, id_in;
   logic                        found_ff, found_in;
   logic [bis_pkg::IDX_W-1:0]   slot_ff, slot_in;
   logic                        ok_ff, ok_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_ok_ff, rsp_ok_in;
   logic                        rsp_found_ff, rsp_found_in;
   logic [bis_pkg::POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [bis_pkg::CNT_OUT_W-1:0] rsp_count_ff, rsp_count_in;

   logic                        accept;
   logic                        rsp_free;
   logic                        scan_start;
   logic                        scan_run;
   logic                        scan_rd_en;
   logic [bis_pkg::IDX_W-1:0]   scan_rd_addr;
   bis_pkg::scan_stat_type      stat;
   bis_pkg::mem_req_type        mem_req;
   logic [bis_pkg::ID_W-1:0]    rd_data;
   logic                        add_ok;
   logic                        rsp_load;

   assign accept   = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign add_ok   = (id_ff != bis_pkg::NULL_ID) && !found_ff && (count_ff < bis_pkg::CAP_CNT);

   bis_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (scan_start),
      .run     (scan_run),
      .count   (count_ff),
      .id      (id_ff),
      .rd_data (rd_data),
      .rd_en   (scan_rd_en),
      .rd_addr (scan_rd_addr),
      .stat    (stat)
   );

   bis_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // Advance the sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bis_pkg::S_IDLE: begin
            if (req_valid) begin
               if ((req_id == bis_pkg::NULL_ID) || (count_ff == '0)) begin
                  state_in = bis_pkg::S_RESOLVE;
               end else begin
                  state_in = bis_pkg::S_SCAN;
               end
            end
         end
         bis_pkg::S_SCAN: begin
            if (stat.hit || stat.miss) begin
               state_in = bis_pkg::S_RESOLVE;
            end
         end
         bis_pkg::S_RESOLVE: begin
            if ((action_ff == bis_pkg::ACT_DELETE) && found_ff) begin
               state_in = bis_pkg::S_LAST_RD;
            end else begin
               state_in = bis_pkg::S_DONE;
            end
         end
         bis_pkg::S_LAST_RD: state_in = bis_pkg::S_LAST_WR;
         bis_pkg::S_LAST_WR: state_in = bis_pkg::S_DONE;
         bis_pkg::S_DONE: begin
            if (rsp_free) begin
               state_in = bis_pkg::S_IDLE;
            end
         end
         default: state_in = bis_pkg::S_IDLE;
      endcase
   end

   // Drive handshake, search and memory controls from the state
   always_comb begin
      req_ready       = 1'b0;
      scan_run        = 1'b0;
      rsp_load        = 1'b0;
      mem_req.rd_en   = scan_rd_en;
      mem_req.rd_addr = scan_rd_addr;
      mem_req.we      = 1'b0;
      mem_req.wr_addr = bis_pkg::IDX_W'(count_ff);
      mem_req.wr_data = id_ff;
      case (state_ff)
         bis_pkg::S_IDLE: req_ready = 1'b1;
         bis_pkg::S_SCAN: scan_run = 1'b1;
         bis_pkg::S_RESOLVE: begin
            mem_req.we = (action_ff == bis_pkg::ACT_ADD) && add_ok;
         end
         bis_pkg::S_LAST_RD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = bis_pkg::IDX_W'(count_ff - bis_pkg::CNT_W'(1));
         end
         bis_pkg::S_LAST_WR: begin
            mem_req.we      = 1'b1;
            mem_req.wr_addr = slot_ff;
            mem_req.wr_data = rd_data;
         end
         bis_pkg::S_DONE: rsp_load = rsp_free;
         default: req_ready = 1'b0;
      endcase
   end

   assign scan_start = accept;

   // Hold the transaction, the search outcome and the count
   always_comb begin
      action_in = action_ff;
      id_in     = id_ff;
      found_in  = found_ff;
      slot_in   = slot_ff;
      ok_in     = ok_ff;
      count_in  = count_ff;
      if (accept) begin
         action_in = req_action;
         id_in     = req_id;
         found_in  = 1'b0;
         slot_in   = '0;
         ok_in     = 1'b0;
      end
      if ((state_ff == bis_pkg::S_SCAN) && stat.hit) begin
         found_in = 1'b1;
         slot_in  = stat.idx;
      end
      if (state_ff == bis_pkg::S_RESOLVE) begin
         case (action_ff)
            bis_pkg::ACT_ADD: begin
               ok_in = add_ok;
               if (add_ok) begin
                  count_in = count_ff + bis_pkg::CNT_W'(1);
               end
            end
            bis_pkg::ACT_DELETE: ok_in = found_ff;
            bis_pkg::ACT_QUERY:  ok_in = found_ff;
            default:             ok_in = 1'b0;
         endcase
      end
      if (state_ff == bis_pkg::S_LAST_WR) begin
         count_in = count_ff - bis_pkg::CNT_W'(1);
      end
   end

   // Load the result register when it is free
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_found_in = rsp_found_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_count_in = rsp_count_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = ok_ff;
         rsp_found_in = found_ff;
         rsp_pos_in   = bis_pkg::POS_W'(slot_ff);
         rsp_count_in = bis_pkg::CNT_OUT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bis_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      action_ff    <= action_in;
      id_ff        <= id_in;
      found_ff     <= found_in;
      slot_ff      <= slot_in;
      ok_ff        <= ok_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_found_ff <= rsp_found_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ok       = rsp_ok_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_count    = rsp_count_ff;

endmodule

[hdl/bis_checker.sv]
// Port checker of the bounded id set unit and its bind to the top level
`include "bounded_id_set_unit_assert.svh"

module bis_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic [bis_pkg::ACT_W-1:0]         req_action,
   input  logic signed [bis_pkg::ID_W-1:0]   req_id,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              rsp_ok,
   input  logic                              rsp_found,
   input  logic [bis_pkg::POS_W-1:0]         rsp_position,
   input  logic [bis_pkg::CNT_OUT_W-1:0]     rsp_count
);

   // A stalled result transaction keeps its payload
   `BIS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_ok, rsp_found, rsp_position, rsp_count}), "result changed while stalled")

   // An accepted request makes the unit busy in the next cycle
   `BIS_ASSERT(a_busy_after_req, clock, reset, req_valid && req_ready |=> !req_ready, "request taken while busy")

   // A successful step without a hit can only be an add, so the set is not empty
   `BIS_ASSERT(a_ok_add_count, clock, reset, rsp_valid && rsp_ok && !rsp_found |-> rsp_count != 0 && rsp_position == 0, "successful add with bad count or position")

   // Reset drops any pending result
   `BIS_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind bounded_id_set_unit bis_checker u_checker (.*);
